[rtl/sgs_pkg.sv]
// sgs_pkg: shared constants and types for the savitzky-golay smoother
// no dependencies
`default_nettype none
package sgs_pkg;
  localparam int MAX_WIDTH_DEF   = 15;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int WEIGHT_BITS_DEF = 20;
  localparam int WEIGHT_FRAC     = 16;
  localparam int MIN_WIDTH       = 5;
  localparam int CFG_BITS        = 4;
  localparam int ROW_BITS        = 4;

  // classification of one queued transaction
  typedef struct packed {
    logic is_weight;
    logic wr_ok;
    logic last;
  } sgs_kind_t;
endpackage
`default_nettype wire

[rtl/savitzky_golay_smoother.sv]
// savitzky_golay_smoother: top level, front queue, back sequencer, weight ram
// depends on sgs_pkg, sgs_ram, sgs_front, sgs_back
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | mode, sample, record_end, weight_row/col/value
//  out     | output    | out_valid/out_ready | smoothed, run_last, record_done
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (window width)
//
// each smoothed result is computed on the one shared multiply-accumulate
// (one tap a cycle from the weight ram, then ram read, product and sum drain)
// echoed results are sent straight from the window; a weight write is done as it is popped from the queue
// reset clears control and counts and sets the width register to MIN_WIDTH; weights and window are not cleared
// a stalled output holds the back end; the two-entry queue keeps the input open until it is full
`default_nettype none
module savitzky_golay_smoother import sgs_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_mode,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_record_end,
  input  wire logic [ROW_BITS-1:0]           in_weight_row,
  input  wire logic [ROW_BITS-1:0]           in_weight_col,
  input  wire logic signed [WEIGHT_BITS-1:0] in_weight_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_smoothed,
  output logic                               out_run_last,
  output logic                               out_record_done,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_BITS-1:0]           cfg_data
);
  localparam int AW = $clog2(MAX_WIDTH * MAX_WIDTH);

  logic                   q_valid, q_pop, ram_we;
  sgs_kind_t              q_kind;
  logic [AW-1:0]          q_addr, ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0] q_weight, ram_wdata, ram_rdata;
  logic [SAMPLE_BITS-1:0] q_sample;

  assign cfg_ready = 1'b1;

  sgs_front #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_BITS(WEIGHT_BITS))
  u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_sample, .in_record_end,
    .in_weight_row, .in_weight_col, .in_weight_value,
    .q_valid, .q_pop, .q_kind, .q_addr, .q_weight, .q_sample
  );

  sgs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_WIDTH * MAX_WIDTH)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  sgs_back #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_BITS(WEIGHT_BITS))
  u_back (
    .clk, .rst_n, .cfg_valid(cfg_valid && cfg_ready), .cfg_data,
    .q_valid, .q_pop, .q_kind, .q_addr, .q_weight, .q_sample,
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata,
    .out_valid, .out_ready, .out_smoothed, .out_run_last, .out_record_done
  );
endmodule
`default_nettype wire

[rtl/sgs_ram.sv]
// sgs_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module sgs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 225
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/sgs_front.sv]
// sgs_front: accepts input transactions, classifies them, two-entry queue
// depends on sgs_pkg
`default_nettype none
module sgs_front import sgs_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int AW = $clog2(MAX_WIDTH * MAX_WIDTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_mode,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_record_end,
  input  wire logic [ROW_BITS-1:0]           in_weight_row,
  input  wire logic [ROW_BITS-1:0]           in_weight_col,
  input  wire logic signed [WEIGHT_BITS-1:0] in_weight_value,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output sgs_kind_t                          q_kind,
  output logic [AW-1:0]                      q_addr,
  output logic [WEIGHT_BITS-1:0]             q_weight,
  output logic [SAMPLE_BITS-1:0]             q_sample
);
  sgs_kind_t              kind_r   [2];
  logic [AW-1:0]          addr_r   [2];
  logic [WEIGHT_BITS-1:0] weight_r [2];
  logic [SAMPLE_BITS-1:0] sample_r [2];
  logic                   wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  sgs_kind_t              kind_in;
  logic                   push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);

  always_comb begin
    kind_in.is_weight = in_mode;
    kind_in.wr_ok     = (int'(in_weight_row) < MAX_WIDTH) && (int'(in_weight_col) < MAX_WIDTH);
    kind_in.last      = in_record_end && !in_mode;
  end

  assign q_kind   = kind_r[rp_r];
  assign q_addr   = addr_r[rp_r];
  assign q_weight = weight_r[rp_r];
  assign q_sample = sample_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      kind_r[wp_r]   <= kind_in;
      addr_r[wp_r]   <= AW'(int'(in_weight_row) * MAX_WIDTH + int'(in_weight_col));
      weight_r[wp_r] <= in_weight_value;
      sample_r[wp_r] <= in_sample;
    end
  end
endmodule
`default_nettype wire

[rtl/sgs_back.sv]
// sgs_back: sample window, width register and shared multiply-accumulate sequencer
// depends on sgs_pkg; drives the weight ram ports
`default_nettype none
module sgs_back import sgs_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int AW = $clog2(MAX_WIDTH * MAX_WIDTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire sgs_kind_t                     q_kind,
  input  wire logic [AW-1:0]                 q_addr,
  input  wire logic [WEIGHT_BITS-1:0]        q_weight,
  input  wire logic [SAMPLE_BITS-1:0]        q_sample,
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_waddr,
  output logic [WEIGHT_BITS-1:0]             ram_wdata,
  output logic [AW-1:0]                      ram_raddr,
  input  wire logic signed [WEIGHT_BITS-1:0] ram_rdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_smoothed,
  output logic                               out_run_last,
  output logic                               out_record_done
);
  localparam int IW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int TOP  = (MAX_WIDTH % 2 != 0) ? MAX_WIDTH : MAX_WIDTH - 1;
  localparam int PW   = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACCW = PW + $clog2(MAX_WIDTH) + 2;
  localparam logic [2:0] ST_IDLE = 3'd0, ST_MAC = 3'd1, ST_DRAIN = 3'd2,
                         ST_FIN = 3'd3, ST_ECHO = 3'd4;

  logic [CFG_BITS-1:0]    cfg_r;
  logic [SAMPLE_BITS-1:0] win_r [MAX_WIDTH];
  logic [2:0]             st_r, st_nxt;
  logic [CW-1:0]          seen_r, w_r, k_r, row_r, end_r;
  logic [IW-1:0]          tap_r;
  logic [AW-1:0]          base_r;
  logic                   last_r, v1_r, v2_r;
  logic signed [SAMPLE_BITS-1:0] samp_d_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] acc_r, rnd, hi_lim, lo_lim;
  logic [SAMPLE_BITS-1:0] rnd_sat;
  logic                   out_free, take, issue;
  logic [CW-1:0]          w_eff, p_eff, seen_new, start_row;

  function automatic logic [CW-1:0] eff_width(input logic [CFG_BITS-1:0] v);
    int w;
    w = int'(v);
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    else if (w % 2 == 0) w = w - 1;
    if (w > TOP) w = TOP;
    return CW'(w);
  endfunction

  assign w_eff     = eff_width(cfg_r);
  assign p_eff     = w_eff >> 1;
  assign seen_new  = (int'(seen_r) < MAX_WIDTH) ? seen_r + CW'(1) : seen_r;
  assign start_row = (seen_r < w_eff) ? '0 : p_eff;

  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (st_r == ST_IDLE) && q_valid;
  assign take      = q_pop && !q_kind.is_weight;
  assign issue     = (st_r == ST_MAC);

  assign ram_we    = q_pop && q_kind.is_weight && q_kind.wr_ok;
  assign ram_waddr = q_addr;
  assign ram_wdata = q_weight;
  assign ram_raddr = base_r + AW'(k_r);

  // round to nearest, ties up, then clamp to the sample range
  assign rnd    = (acc_r + (ACCW'(1) <<< (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC;
  assign hi_lim = (ACCW'(1) <<< (SAMPLE_BITS - 1)) - ACCW'(1);
  assign lo_lim = -(ACCW'(1) <<< (SAMPLE_BITS - 1));
  always_comb begin
    if (rnd > hi_lim) rnd_sat = SAMPLE_BITS'(hi_lim);
    else if (rnd < lo_lim) rnd_sat = SAMPLE_BITS'(lo_lim);
    else rnd_sat = rnd[SAMPLE_BITS-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          if (seen_new < w_eff) begin
            if (q_kind.last) st_nxt = ST_ECHO;
          end else begin
            st_nxt = ST_MAC;
          end
        end
      end
      ST_MAC:   if (k_r == w_r - CW'(1)) st_nxt = ST_DRAIN;
      ST_DRAIN: if (!v1_r && !v2_r) st_nxt = ST_FIN;
      ST_FIN:   if (out_free) st_nxt = (row_r == end_r) ? ST_IDLE : ST_MAC;
      ST_ECHO:  if (out_free && k_r == end_r) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cfg_r     <= CFG_BITS'(MIN_WIDTH);
      seen_r    <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) cfg_r <= cfg_data;
      if (take) seen_r <= q_kind.last ? '0 : seen_new;
      v1_r <= issue;
      v2_r <= v1_r;
      if (((st_r == ST_FIN) || (st_r == ST_ECHO)) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end

    if (take) begin
      for (int i = 0; i < MAX_WIDTH - 1; i++) win_r[i] <= win_r[i+1];
      win_r[MAX_WIDTH-1] <= q_sample;
      last_r <= q_kind.last;
      w_r    <= w_eff;
      k_r    <= '0;
      acc_r  <= '0;
      if (seen_new < w_eff) begin
        tap_r <= IW'(MAX_WIDTH - int'(seen_new));
        end_r <= seen_new - CW'(1);
      end else begin
        tap_r  <= IW'(MAX_WIDTH - int'(w_eff));
        row_r  <= start_row;
        end_r  <= q_kind.last ? w_eff - CW'(1) : p_eff;
        base_r <= AW'(int'(start_row) * MAX_WIDTH);
      end
    end

    if (issue) begin
      samp_d_r <= win_r[tap_r];
      k_r      <= k_r + CW'(1);
      tap_r    <= tap_r + IW'(1);
    end
    if (v1_r) prod_r <= samp_d_r * ram_rdata;
    if (v2_r) acc_r <= acc_r + ACCW'(prod_r);

    if ((st_r == ST_FIN) && out_free) begin
      out_smoothed    <= rnd_sat;
      out_run_last    <= (row_r == end_r);
      out_record_done <= last_r && (row_r == end_r);
      row_r  <= row_r + CW'(1);
      base_r <= base_r + AW'(MAX_WIDTH);
      k_r    <= '0;
      tap_r  <= IW'(MAX_WIDTH - int'(w_r));
      acc_r  <= '0;
    end
    if ((st_r == ST_ECHO) && out_free) begin
      out_smoothed    <= win_r[tap_r];
      out_run_last    <= (k_r == end_r);
      out_record_done <= (k_r == end_r);
      k_r   <= k_r + CW'(1);
      tap_r <= tap_r + IW'(1);
    end
  end
endmodule
`default_nettype wire
